>>> rtl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg - shared types and constants
// Field widths, operation and status codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int NUM_PAGES_DEF = 32768;
    localparam int PAGE_BITS_DEF = 12;

    localparam int OP_W        = 2;
    localparam int ADDR_W      = 32;
    localparam int AMOUNT_W    = 8;
    localparam int PAGE_ADDR_W = 27;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 8;
    localparam int FIRST_PAGE_W = 15;

    // APB side
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_FIRST_PAGE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_SEED   = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_ADJUST = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_NONZERO  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_APAGE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic accept;     // latch word, issue count/stack reads
        logic load_page;  // alloc: take popped page, re-read its count
        logic exec;       // update count, stack and result register
        logic clear;      // write one zero count during the clearing pass
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last; // clearing pass at final entry
        logic pop_go;     // incoming word is an alloc with a non-empty stack
        logic out_busy;   // result register full and not being taken
    } dp_status_t;

endpackage

>>> rtl/rpa_if.sv
// ----------------------------------------------------------------------------
// rpa_if - request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rpa_in_if
    import rpa_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic [ADDR_W-1:0]          addr;
    logic signed [AMOUNT_W-1:0] adjust_amount;

    modport source (output valid, op, addr, adjust_amount, input ready);
    modport sink   (input valid, op, addr, adjust_amount, output ready);
endinterface

interface rpa_out_if
    import rpa_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [PAGE_ADDR_W-1:0] page_addr;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_W-1:0]     count_after;
    logic                   released;

    modport source (output valid, page_addr, status, count_after, released, input ready);
    modport sink   (input valid, page_addr, status, count_after, released, output ready);
endinterface

>>> rtl/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl - sequencing state machine
// Clearing pass after reset, then accept / page fetch / execute per word.
// ----------------------------------------------------------------------------
module rpa_ctrl
    import rpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.pop_go ? S_APAGE : S_EXEC;
                end
            end
            S_APAGE:
            begin
                cmd.load_page = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (!status.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/rpa_dp.sv
// ----------------------------------------------------------------------------
// rpa_dp - allocator datapath
// Count memory, free stack memory, address checks, count update and the
// result register.
// ----------------------------------------------------------------------------
module rpa_dp
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [FIRST_PAGE_W-1:0]    first_page,
    input  logic [OP_W-1:0]            in_op,
    input  logic [ADDR_W-1:0]          in_addr,
    input  logic signed [AMOUNT_W-1:0] in_amount,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [PAGE_ADDR_W-1:0]     out_page_addr,
    output logic [STATUS_W-1:0]        out_status,
    output logic [COUNT_W-1:0]         out_count_after,
    output logic                       out_released
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int DW = PW + 1;
    localparam logic [DW-1:0] DEPTH_MAX = DW'(NUM_PAGES);
    localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);

    // memories
    logic [COUNT_W-1:0] cnt_mem [NUM_PAGES];
    logic [PW-1:0]      stk_mem [NUM_PAGES];

    logic [COUNT_W-1:0] cnt_rdata_reg;
    logic [PW-1:0]      stk_rdata_reg;

    // control registers
    logic [DW-1:0] depth_reg;
    logic [PW-1:0] clr_idx_reg;
    logic          out_valid_reg;

    // latched word
    op_t                       op_reg;
    logic [PW-1:0]             page_reg;
    logic signed [AMOUNT_W-1:0] amount_reg;
    logic                      pool_ok_reg;
    logic                      in_range_reg;

    // result payload
    logic [PAGE_ADDR_W-1:0] page_addr_reg;
    status_t                status_reg;
    logic [COUNT_W-1:0]     count_after_reg;
    logic                   released_reg;

    // incoming address checks
    logic [ADDR_W-1:0] page_full;
    logic              in_range;
    logic              aligned;
    logic              pool_ok;
    logic [PW-1:0]     page_in;

    assign page_full = in_addr >> PAGE_BITS;
    assign in_range  = page_full < ADDR_W'(NUM_PAGES);
    assign aligned   = in_addr[PAGE_BITS-1:0] == '0;
    assign pool_ok   = aligned && in_range
                       && (page_full >= ADDR_W'(first_page));
    assign page_in   = in_range ? page_full[PW-1:0] : '0;

    logic depth_zero;
    assign depth_zero = depth_reg == '0;

    // memory port control
    logic          cnt_rd_en;
    logic [PW-1:0] cnt_raddr;
    logic          cnt_we;
    logic [PW-1:0] cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic          stk_rd_en;
    logic [PW-1:0] stk_raddr;
    logic          stk_we;

    assign cnt_rd_en = cmd.accept || cmd.load_page;
    assign cnt_raddr = cmd.load_page ? stk_rdata_reg : page_in;
    assign stk_rd_en = cmd.accept && !depth_zero;
    assign stk_raddr = depth_reg[PW-1:0] - 1'b1;

    // execute-step results
    status_t            ex_status;
    logic [COUNT_W-1:0] ex_count;
    logic               ex_touch;
    logic               ex_push_req;
    logic               ex_push;
    logic               ex_pop;
    logic [PAGE_ADDR_W-1:0] ex_page_addr;
    logic signed [COUNT_W+1:0] adj_sum;
    logic [63:0]        wide_addr;

    assign wide_addr = 64'(page_reg) << PAGE_BITS;
    assign adj_sum   = $signed({2'b00, cnt_rdata_reg})
                       + $signed({{2{amount_reg[AMOUNT_W-1]}}, amount_reg});

    always_comb
    begin
        ex_status    = ST_OK;
        ex_count     = '0;
        ex_touch     = 1'b0;
        ex_push_req  = 1'b0;
        ex_pop       = 1'b0;
        ex_page_addr = '0;
        case (op_reg)
            OP_SEED:
            begin
                if (!pool_ok_reg)
                begin
                    ex_status = ST_BAD_ADDR;
                end
                else
                begin
                    ex_touch    = 1'b1;
                    ex_push_req = 1'b1;
                end
            end
            OP_ALLOC:
            begin
                if (depth_zero)
                begin
                    ex_status = ST_EMPTY;
                end
                else
                begin
                    if (cnt_rdata_reg != '0)
                    begin
                        ex_status = ST_NONZERO;
                    end
                    ex_touch     = 1'b1;
                    ex_pop       = 1'b1;
                    ex_count     = COUNT_W'(1);
                    ex_page_addr = wide_addr[PAGE_ADDR_W-1:0];
                end
            end
            OP_FREE:
            begin
                if (!pool_ok_reg)
                begin
                    ex_status = ST_BAD_ADDR;
                end
                else
                begin
                    ex_touch = 1'b1;
                    if (cnt_rdata_reg != '0)
                    begin
                        ex_count = cnt_rdata_reg - 1'b1;
                    end
                    ex_push_req = (ex_count == '0);
                end
            end
            OP_ADJUST:
            begin
                if (!in_range_reg)
                begin
                    ex_status = ST_BAD_ADDR;
                end
                else
                begin
                    ex_touch = 1'b1;
                    if (adj_sum < 0)
                    begin
                        ex_count = '0;
                    end
                    else if (adj_sum > $signed((COUNT_W+2)'(255)))
                    begin
                        ex_count = '1;
                    end
                    else
                    begin
                        ex_count = adj_sum[COUNT_W-1:0];
                    end
                end
            end
            default:
            begin
                ex_status = ST_OK;
            end
        endcase
    end

    // a push onto a full stack is dropped
    assign ex_push = ex_push_req && (depth_reg < DEPTH_MAX);

    assign cnt_we    = cmd.clear || (cmd.exec && ex_touch);
    assign cnt_waddr = cmd.clear ? clr_idx_reg : page_reg;
    assign cnt_wdata = cmd.clear ? '0 : ex_count;
    assign stk_we    = cmd.exec && ex_push;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_rd_en)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[depth_reg[PW-1:0]] <= page_reg;
        end
        if (stk_rd_en)
        begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.exec && ex_push)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            else if (cmd.exec && ex_pop)
            begin
                depth_reg <= depth_reg - 1'b1;
            end
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= op_t'(in_op);
            page_reg     <= page_in;
            amount_reg   <= in_amount;
            pool_ok_reg  <= pool_ok;
            in_range_reg <= in_range;
        end
        else if (cmd.load_page)
        begin
            page_reg <= stk_rdata_reg;
        end
        if (cmd.exec)
        begin
            page_addr_reg   <= ex_page_addr;
            status_reg      <= ex_status;
            count_after_reg <= ex_count;
            released_reg    <= ex_push;
        end
    end

    assign status.clear_last = clr_idx_reg == LAST_PAGE;
    assign status.pop_go     = (op_t'(in_op) == OP_ALLOC) && !depth_zero;
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign out_page_addr   = page_addr_reg;
    assign out_status      = status_reg;
    assign out_count_after = count_after_reg;
    assign out_released    = released_reg;

endmodule

>>> rtl/refcounted_page_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator - page frame allocator with reference counts
// Request words carry op/addr/adjust_amount on cmd; each gives exactly one
// response word on rsp (page_addr, status, count_after, released).
//
// Use: after reset the block runs a clearing pass over every entry of the
// count memory, one entry a cycle; cmd.ready stays low until it ends.
// APB writes to first_page are taken throughout.
// Steps: seed, free and adjust have an accept step (count read), then an
// execute step (count write) that loads the response register on rsp.
// Alloc from a non-empty stack adds a page step between them, as the popped
// page comes out of the stack memory before its count can be read.
// One word is in flight at a time; a new word is accepted once the previous
// one has been executed, even while its response still waits on rsp.
// A stalled rsp holds the response; a following word then waits in its
// execute step until the response register frees up.
// ----------------------------------------------------------------------------
module refcounted_page_allocator
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    rpa_in_if.sink                cmd,
    rpa_out_if.source             rsp,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // configuration register: register index is the word address
    logic [FIRST_PAGE_W-1:0] first_page_reg;
    logic                    reg_idx;
    logic                    cfg_write;

    assign reg_idx   = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= '0;
        end
        else if (cfg_write && (reg_idx == REG_FIRST_PAGE))
        begin
            first_page_reg <= pwdata[FIRST_PAGE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_FIRST_PAGE)
        begin
            prdata = APB_DATA_W'(first_page_reg);
        end
    end

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       in_ready;

    assign cmd.ready = in_ready;

    rpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    rpa_dp #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .first_page      (first_page_reg),
        .in_op           (cmd.op),
        .in_addr         (cmd.addr),
        .in_amount       (cmd.adjust_amount),
        .cmd             (dp_cmd),
        .status          (dp_status),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_page_addr   (rsp.page_addr),
        .out_status      (rsp.status),
        .out_count_after (rsp.count_after),
        .out_released    (rsp.released)
    );

endmodule
